>>> design/krct_pkg.sv
// krct_pkg: shared constants and types for the keyed remainder carry truncator
// holds table geometry, fixed-point widths and the packed table entry layout
// no dependencies
package krct_pkg;

    localparam int ENTRIES     = 16;
    localparam int FRAC_BITS   = 16;
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 48;
    localparam int RESULT_W    = 32;
    localparam int AGE_W       = 8;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W       = IDX_W + 1;
    localparam int REM_W       = FRAC_BITS + 1;
    localparam int SUM_W       = VALUE_W + 1;
    localparam int QMAG_W      = SUM_W - FRAC_BITS;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = AGE_W'(100);
    localparam logic [AGE_W-1:0] AGE_MAX         = {AGE_W{1'b1}};

    localparam logic REQ_CONVERT = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [REM_W-1:0] rem;
        logic [AGE_W-1:0]        age;
    } entry_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result;
        logic signed [REM_W-1:0]    rem;
        logic                       sat;
    } quant_t;

endpackage

>>> design/krct_if.sv
// krct_if: valid/ready channel interfaces for request, result and configuration items
// depends on krct_pkg for field widths
interface krct_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [krct_pkg::KEY_W-1:0]          key;
    logic signed [krct_pkg::VALUE_W-1:0] value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface krct_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [krct_pkg::RESULT_W-1:0] result;
    logic                                 table_full;
    logic                                 saturated;

    modport source (output valid, output result, output table_full, output saturated,
                    input ready);
    modport sink   (input valid, input result, input table_full, input saturated,
                    output ready);
endinterface

interface krct_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [krct_pkg::AGE_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/krct_quant.sv
// krct_quant: truncates a signed fixed-point sum toward zero with 32-bit saturation
// returns the integer, the signed fraction left over and the clamp flag
// depends on krct_pkg
module krct_quant
(
    input  logic signed [krct_pkg::SUM_W-1:0] sum,
    output krct_pkg::quant_t                  q
);

    logic                               neg;
    logic [krct_pkg::SUM_W-1:0]         mag;
    logic [krct_pkg::QMAG_W-1:0]        qmag;
    logic [krct_pkg::FRAC_BITS-1:0]     fmag;
    logic [63:0]                        qwide;
    logic [63:0]                        qsigned;
    logic                               sat_pos;
    logic                               sat_neg;

    always_comb
    begin
        neg     = sum[krct_pkg::SUM_W-1];
        mag     = neg ? krct_pkg::SUM_W'(-sum) : krct_pkg::SUM_W'(sum);
        qmag    = mag[krct_pkg::SUM_W-1:krct_pkg::FRAC_BITS];
        fmag    = mag[krct_pkg::FRAC_BITS-1:0];
        qwide   = 64'(qmag);
        qsigned = neg ? (64'd0 - qwide) : qwide;
        sat_pos = !neg && (qwide > 64'h0000_0000_7FFF_FFFF);
        sat_neg = neg && (qwide > 64'h0000_0000_8000_0000);

        q.sat = sat_pos || sat_neg;
        if (sat_pos)
        begin
            q.result = {1'b0, {(krct_pkg::RESULT_W-1){1'b1}}};
        end
        else if (sat_neg)
        begin
            q.result = {1'b1, {(krct_pkg::RESULT_W-1){1'b0}}};
        end
        else
        begin
            q.result = qsigned[krct_pkg::RESULT_W-1:0];
        end
        q.rem = neg ? (krct_pkg::REM_W'(0) - krct_pkg::REM_W'({1'b0, fmag}))
                    : krct_pkg::REM_W'({1'b0, fmag});
    end

endmodule

>>> design/keyed_remainder_carry_truncator.sv
// keyed_remainder_carry_truncator: per-key remainder carrying fixed-point truncator
// table of keys, remainders and ages in one synchronous memory, valid bits in flops
// depends on krct_pkg, krct_if and krct_quant
//
// usage
//   req: one item per request; req_type 0 converts value for key, 1 is a frame tick
//   rsp: one item per convert (result, table_full, saturated); ticks give none
//   cfg: writes age_limit; always ready, write only while the block is idle
// timing
//   a request walks all 16 table entries through the memory read port, one per
//   cycle, then a convert also passes ST_SUM and ST_FINISH to the result register;
//   one request is in flight at a time
//   the result register holds while rsp is stalled; the next request is still
//   taken, and its result waits until the held item has gone
// reset
//   all entries invalid, age_limit 100, no result pending; no clearing pass
module keyed_remainder_carry_truncator
(
    input  logic          clk,
    input  logic          rst_n,
    krct_req_if.sink      req,
    krct_rsp_if.source    rsp,
    krct_cfg_if.sink      cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUM,
        ST_FINISH
    } st_t;

    st_t                                  state_reg;
    logic                                 type_reg;
    logic [krct_pkg::KEY_W-1:0]           key_reg;
    logic signed [krct_pkg::VALUE_W-1:0]  value_reg;
    logic [krct_pkg::AGE_W-1:0]           age_limit_reg;
    logic [krct_pkg::ENTRIES-1:0]         valid_reg;
    logic [krct_pkg::CNT_W-1:0]           cnt_reg;
    logic                                 rd_vld_reg;
    logic [krct_pkg::IDX_W-1:0]           rd_idx_reg;
    krct_pkg::entry_t                     rd_data_reg;
    logic                                 hit_reg;
    logic                                 free_found_reg;
    logic [krct_pkg::IDX_W-1:0]           hit_idx_reg;
    logic [krct_pkg::IDX_W-1:0]           free_idx_reg;
    logic signed [krct_pkg::REM_W-1:0]    hit_rem_reg;
    logic [krct_pkg::IDX_W-1:0]           slot_reg;
    logic                                 full_reg;
    logic signed [krct_pkg::SUM_W-1:0]    sum_reg;
    logic                                 out_valid_reg;
    logic signed [krct_pkg::RESULT_W-1:0] out_result_reg;
    logic                                 out_full_reg;
    logic                                 out_sat_reg;

    krct_pkg::entry_t                     mem [krct_pkg::ENTRIES];

    logic                                 scan_done;
    logic                                 rd_ok;
    logic                                 rd_entry_valid;
    logic [krct_pkg::AGE_W-1:0]           age_next;
    logic                                 out_free;
    logic                                 mem_we;
    logic [krct_pkg::IDX_W-1:0]           mem_waddr;
    krct_pkg::entry_t                     mem_wdata;
    krct_pkg::quant_t                     quant;

    krct_quant u_quant
    (
        .sum (sum_reg),
        .q   (quant)
    );

    assign req.ready      = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.result     = out_result_reg;
    assign rsp.table_full = out_full_reg;
    assign rsp.saturated  = out_sat_reg;

    always_comb
    begin
        scan_done      = (cnt_reg == krct_pkg::CNT_W'(krct_pkg::ENTRIES));
        rd_ok          = rd_vld_reg && (state_reg == ST_SCAN);
        rd_entry_valid = valid_reg[rd_idx_reg];
        age_next       = (rd_data_reg.age == krct_pkg::AGE_MAX) ? rd_data_reg.age
                                                               : rd_data_reg.age + 1'b1;
        out_free       = !out_valid_reg || rsp.ready;

        mem_we    = 1'b0;
        mem_waddr = rd_idx_reg;
        mem_wdata = rd_data_reg;
        if (rd_ok && (type_reg == krct_pkg::REQ_TICK) && rd_entry_valid)
        begin
            mem_we        = 1'b1;
            mem_wdata.age = age_next;
        end
        else if ((state_reg == ST_FINISH) && out_free && !full_reg)
        begin
            mem_we        = 1'b1;
            mem_waddr     = slot_reg;
            mem_wdata.key = key_reg;
            mem_wdata.rem = quant.rem;
            mem_wdata.age = '0;
        end
    end

    // table memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[cnt_reg[krct_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            age_limit_reg  <= krct_pkg::AGE_LIMIT_RESET;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            full_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                age_limit_reg <= cfg.data;
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        type_reg       <= req.req_type;
                        key_reg        <= req.key;
                        value_reg      <= req.value;
                        cnt_reg        <= '0;
                        rd_vld_reg     <= 1'b0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    // issue side
                    if (!scan_done)
                    begin
                        cnt_reg    <= cnt_reg + 1'b1;
                        rd_idx_reg <= cnt_reg[krct_pkg::IDX_W-1:0];
                        rd_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_vld_reg <= 1'b0;
                    end

                    // data side
                    if (rd_vld_reg)
                    begin
                        if (type_reg == krct_pkg::REQ_TICK)
                        begin
                            if (rd_entry_valid && (age_next >= age_limit_reg))
                            begin
                                valid_reg[rd_idx_reg] <= 1'b0;
                            end
                        end
                        else
                        begin
                            if (rd_entry_valid && !hit_reg && (rd_data_reg.key == key_reg))
                            begin
                                hit_reg     <= 1'b1;
                                hit_idx_reg <= rd_idx_reg;
                                hit_rem_reg <= rd_data_reg.rem;
                            end
                            if (!rd_entry_valid && !free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= rd_idx_reg;
                            end
                        end
                    end

                    if (scan_done && !rd_vld_reg)
                    begin
                        state_reg <= (type_reg == krct_pkg::REQ_TICK) ? ST_IDLE : ST_SUM;
                    end
                end

                ST_SUM:
                begin
                    // a new entry starts with zero carry
                    sum_reg   <= krct_pkg::SUM_W'(value_reg)
                               + (hit_reg ? krct_pkg::SUM_W'(hit_rem_reg)
                                          : krct_pkg::SUM_W'(0));
                    slot_reg  <= hit_reg ? hit_idx_reg : free_idx_reg;
                    full_reg  <= !hit_reg && !free_found_reg;
                    state_reg <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_result_reg <= quant.result;
                        out_full_reg   <= full_reg;
                        out_sat_reg    <= quant.sat;
                        if (!full_reg)
                        begin
                            valid_reg[slot_reg] <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
